// ----- rtl/irpw_pkg.sv -----
package irpw_pkg;

  // register map, index is paddr[4:2]
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_CARRIER_PERIOD  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CARRIER_COMPARE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_MARK      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAP             = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MARK        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MARK       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_MS    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BITS_IN_USE     = 3'd7;

  // field widths
  localparam int unsigned CARRIER_W = 16;
  localparam int unsigned TICKS_W   = 24;
  localparam int unsigned MS_W      = 20;
  localparam int unsigned BITS_W    = 6;
  localparam int unsigned WORD_W    = 32;

  // longest frame the data word can carry
  localparam logic [BITS_W-1:0] MAX_BITS = 6'd32;
  // tail gap is this many gap lengths
  localparam logic [BITS_W-1:0] TAIL_GAPS = 6'd3;

  // reset values of the registers
  localparam logic [CARRIER_W-1:0] RST_CARRIER_PERIOD  = 16'd421;
  localparam logic [CARRIER_W-1:0] RST_CARRIER_COMPARE = 16'd210;
  localparam logic [TICKS_W-1:0]   RST_START_MARK      = 24'd38400;
  localparam logic [TICKS_W-1:0]   RST_GAP             = 24'd9600;
  localparam logic [TICKS_W-1:0]   RST_ONE_MARK        = 24'd19200;
  localparam logic [TICKS_W-1:0]   RST_ZERO_MARK       = 24'd9600;
  localparam logic [MS_W-1:0]      RST_TICKS_PER_MS    = 20'd16000;
  localparam logic [BITS_W-1:0]    RST_BITS_IN_USE     = 6'd32;

endpackage

// ----- rtl/ir_pulse_width_frame_sender_unit.sv -----
// Pulse-width coded infrared transmitter. Every accepted input word is one
// clock tick of the transmitter; a word with in_cmd set while idle starts
// sending in_payload (LSB first) as repeated frames of start mark, gap plus
// long or short mark per bit, and a tail of three gaps, until in_duration_ms
// milliseconds have passed (at least one frame). One result word comes out
// per input word, in the cycle after it is accepted; a new word is taken every
// cycle as long as out_ready keeps the output register draining, so the
// throughput is one tick per clock. Timing registers on the APB port must be
// written only while out_busy_res is low and no word is in flight.
module ir_pulse_width_frame_sender_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [irpw_pkg::WORD_W-1:0]   in_payload,
  input  logic [irpw_pkg::WORD_W-1:0]   in_duration_ms,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ir_pin,
  output logic                          out_busy_res,
  output logic                          out_in_mark,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpw_pkg::PADDR_W-1:0]  paddr,
  input  logic [irpw_pkg::PDATA_W-1:0]  pwdata,
  output logic [irpw_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import irpw_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_GAP   = 3'd2,
    PH_MARK  = 3'd3,
    PH_TAIL  = 3'd4
  } phase_t;

  // configuration registers
  logic [CARRIER_W-1:0] carrier_period_r, carrier_compare_r;
  logic [TICKS_W-1:0]   start_mark_r, gap_r, one_mark_r, zero_mark_r;
  logic [MS_W-1:0]      ticks_per_ms_r;
  logic [BITS_W-1:0]    bits_in_use_r;

  // sender state
  phase_t               phase_r, phase_nxt;
  logic [TICKS_W-1:0]   timer_r, timer_nxt;
  logic [BITS_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [WORD_W-1:0]    data_word_r, data_word_nxt;
  logic [CARRIER_W-1:0] carrier_r, carrier_nxt;
  logic [MS_W-1:0]      ms_ticks_r, ms_ticks_nxt;
  logic [WORD_W-1:0]    elapsed_r, elapsed_nxt;
  logic [WORD_W-1:0]    limit_r, limit_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_ir_pin_r, out_busy_r, out_mark_r;

  logic                 accept, cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  // view of the state once a start on this tick is applied
  logic                 start;
  phase_t               cur_phase;
  logic [TICKS_W-1:0]   cur_timer, timer_inc;
  logic [BITS_W-1:0]    cur_bit, bit_inc;
  logic [WORD_W-1:0]    cur_data, cur_limit, cur_elapsed, elapsed_step;
  logic [CARRIER_W-1:0] cur_carrier;
  logic [MS_W-1:0]      cur_ms, ms_inc, tpm_eff;
  logic [BITS_W-1:0]    frame_bits;
  logic [TICKS_W-1:0]   phase_len;
  logic                 busy, mark, pin;

  assign accept   = in_valid & in_ready;
  assign in_ready = ~out_valid_r | out_ready;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[PADDR_W-1:2];
  assign pready   = 1'b1;

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_CARRIER_PERIOD:  prdata = {{(PDATA_W-CARRIER_W){1'b0}}, carrier_period_r};
      REG_CARRIER_COMPARE: prdata = {{(PDATA_W-CARRIER_W){1'b0}}, carrier_compare_r};
      REG_START_MARK:      prdata = {{(PDATA_W-TICKS_W){1'b0}}, start_mark_r};
      REG_GAP:             prdata = {{(PDATA_W-TICKS_W){1'b0}}, gap_r};
      REG_ONE_MARK:        prdata = {{(PDATA_W-TICKS_W){1'b0}}, one_mark_r};
      REG_ZERO_MARK:       prdata = {{(PDATA_W-TICKS_W){1'b0}}, zero_mark_r};
      REG_TICKS_PER_MS:    prdata = {{(PDATA_W-MS_W){1'b0}}, ticks_per_ms_r};
      REG_BITS_IN_USE:     prdata = {{(PDATA_W-BITS_W){1'b0}}, bits_in_use_r};
      default:             prdata = '0;
    endcase
  end

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_period_r  <= RST_CARRIER_PERIOD;
      carrier_compare_r <= RST_CARRIER_COMPARE;
      start_mark_r      <= RST_START_MARK;
      gap_r             <= RST_GAP;
      one_mark_r        <= RST_ONE_MARK;
      zero_mark_r       <= RST_ZERO_MARK;
      ticks_per_ms_r    <= RST_TICKS_PER_MS;
      bits_in_use_r     <= RST_BITS_IN_USE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CARRIER_PERIOD:  carrier_period_r  <= pwdata[CARRIER_W-1:0];
        REG_CARRIER_COMPARE: carrier_compare_r <= pwdata[CARRIER_W-1:0];
        REG_START_MARK:      start_mark_r      <= pwdata[TICKS_W-1:0];
        REG_GAP:             gap_r             <= pwdata[TICKS_W-1:0];
        REG_ONE_MARK:        one_mark_r        <= pwdata[TICKS_W-1:0];
        REG_ZERO_MARK:       zero_mark_r       <= pwdata[TICKS_W-1:0];
        REG_TICKS_PER_MS:    ticks_per_ms_r    <= pwdata[MS_W-1:0];
        REG_BITS_IN_USE:     bits_in_use_r     <= pwdata[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // apply a start command to the current state
  always_comb begin
    start       = (phase_r == PH_IDLE) && in_cmd;
    cur_phase   = start ? PH_START : phase_r;
    cur_timer   = start ? '0 : timer_r;
    cur_bit     = start ? '0 : bit_idx_r;
    cur_data    = start ? in_payload : data_word_r;
    cur_limit   = start ? in_duration_ms : limit_r;
    cur_elapsed = start ? '0 : elapsed_r;
    cur_carrier = start ? '0 : carrier_r;
    cur_ms      = start ? '0 : ms_ticks_r;
  end

  // pin level for this tick
  always_comb begin
    busy = (cur_phase != PH_IDLE);
    mark = (cur_phase == PH_START) || (cur_phase == PH_MARK);
    pin  = mark ? (cur_carrier <= carrier_compare_r) : 1'b1;
  end

  // phase length, zero lengths act as one tick
  always_comb begin
    frame_bits = (bits_in_use_r > MAX_BITS) ? MAX_BITS : bits_in_use_r;
    tpm_eff    = (ticks_per_ms_r == '0) ? MS_W'(1) : ticks_per_ms_r;
    unique case (cur_phase)
      PH_START: phase_len = start_mark_r;
      PH_MARK:  phase_len = cur_data[cur_bit[4:0]] ? one_mark_r : zero_mark_r;
      default:  phase_len = gap_r;
    endcase
    if (phase_len == '0) begin
      phase_len = TICKS_W'(1);
    end
  end

  // advance counters and phase on a busy tick
  always_comb begin
    phase_nxt     = cur_phase;
    timer_nxt     = cur_timer;
    bit_idx_nxt   = cur_bit;
    data_word_nxt = cur_data;
    limit_nxt     = cur_limit;
    elapsed_nxt   = cur_elapsed;
    carrier_nxt   = cur_carrier;
    ms_ticks_nxt  = cur_ms;
    timer_inc     = cur_timer + TICKS_W'(1);
    bit_inc       = cur_bit + BITS_W'(1);
    ms_inc        = cur_ms + MS_W'(1);
    elapsed_step  = cur_elapsed;
    if (busy) begin
      carrier_nxt = (cur_carrier >= carrier_period_r) ? '0 : cur_carrier + CARRIER_W'(1);
      // millisecond bookkeeping, elapsed saturates
      if (ms_inc >= tpm_eff) begin
        ms_ticks_nxt = '0;
        if (cur_elapsed != '1) begin
          elapsed_step = cur_elapsed + WORD_W'(1);
        end
      end else begin
        ms_ticks_nxt = ms_inc;
      end
      elapsed_nxt = elapsed_step;
      timer_nxt   = timer_inc;
      if (timer_inc >= phase_len) begin
        timer_nxt = '0;
        unique case (cur_phase)
          PH_START: begin
            bit_idx_nxt = '0;
            phase_nxt   = (frame_bits != '0) ? PH_GAP : PH_TAIL;
          end
          PH_GAP: phase_nxt = PH_MARK;
          PH_MARK: begin
            if (bit_inc < frame_bits) begin
              bit_idx_nxt = bit_inc;
              phase_nxt   = PH_GAP;
            end else begin
              bit_idx_nxt = '0;
              phase_nxt   = PH_TAIL;
            end
          end
          default: begin
            bit_idx_nxt = bit_inc;
            if (bit_inc >= TAIL_GAPS) begin
              bit_idx_nxt = '0;
              if (elapsed_step < cur_limit) begin
                phase_nxt = PH_START;
              end else begin
                phase_nxt   = PH_IDLE;
                carrier_nxt = '0;
              end
            end
          end
        endcase
      end
    end
  end

  assign out_valid_nxt = accept | (out_valid_r & ~out_ready);

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      timer_r      <= '0;
      bit_idx_r    <= '0;
      data_word_r  <= '0;
      carrier_r    <= '0;
      ms_ticks_r   <= '0;
      elapsed_r    <= '0;
      limit_r      <= '0;
      out_valid_r  <= 1'b0;
      out_ir_pin_r <= 1'b1;
      out_busy_r   <= 1'b0;
      out_mark_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r      <= phase_nxt;
        timer_r      <= timer_nxt;
        bit_idx_r    <= bit_idx_nxt;
        data_word_r  <= data_word_nxt;
        carrier_r    <= carrier_nxt;
        ms_ticks_r   <= ms_ticks_nxt;
        elapsed_r    <= elapsed_nxt;
        limit_r      <= limit_nxt;
        out_ir_pin_r <= pin;
        out_busy_r   <= busy;
        out_mark_r   <= mark;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ir_pin   = out_ir_pin_r;
  assign out_busy_res = out_busy_r;
  assign out_in_mark  = out_mark_r;

endmodule

// ----- rtl/irpw_checker.sv -----
module irpw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic out_ir_pin,
  input logic out_busy_res,
  input logic out_in_mark
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ir_pin)
      && $stable(out_busy_res) && $stable(out_in_mark))
    else $error("result word changed while stalled");

  // pin idles high outside marks
  a_pin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_mark |-> out_ir_pin)
    else $error("pin low outside a mark");

  // carrier only while sending
  a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_mark |-> out_busy_res)
    else $error("mark while not busy");

  // draining output always frees the input side
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled with output draining");

  // a start while idle shows up busy in its own result word
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> out_valid && out_busy_res)
    else $error("start word not reported busy");

endmodule

bind ir_pulse_width_frame_sender_unit irpw_checker u_irpw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_ir_pin   (out_ir_pin),
  .out_busy_res (out_busy_res),
  .out_in_mark  (out_in_mark)
);

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irpw_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_GAP   = 3'd2,
    PH_MARK  = 3'd3,
    PH_TAIL  = 3'd4
  } frame_phase_t;

  typedef struct packed {
    logic pin;
    logic busy;
    logic mark;
  } pin_levels_t;

  // tracks the transmitter tick by tick and checks the pin levels it drives
  class ir_frame_scoreboard;
    logic [CARRIER_W-1:0] carrier_top, carrier_cmp;
    logic [TICKS_W-1:0]   start_len, gap_len, one_len, zero_len;
    logic [MS_W-1:0]      ms_len;
    logic [BITS_W-1:0]    bit_count;

    frame_phase_t         phase;
    logic [TICKS_W-1:0]   phase_ticks;
    logic [BITS_W-1:0]    bit_idx;
    logic [WORD_W-1:0]    data_word, elapsed_ms, limit_ms;
    logic [CARRIER_W-1:0] carrier_cnt;
    logic [MS_W-1:0]      ms_cnt;

    pin_levels_t          expected_levels[$];
    int unsigned          errors;

    function new();
      carrier_top = RST_CARRIER_PERIOD;
      carrier_cmp = RST_CARRIER_COMPARE;
      start_len   = RST_START_MARK;
      gap_len     = RST_GAP;
      one_len     = RST_ONE_MARK;
      zero_len    = RST_ZERO_MARK;
      ms_len      = RST_TICKS_PER_MS;
      bit_count   = RST_BITS_IN_USE;
      phase       = PH_IDLE;
      phase_ticks = '0;
      bit_idx     = '0;
      data_word   = '0;
      elapsed_ms  = '0;
      limit_ms    = '0;
      carrier_cnt = '0;
      ms_cnt      = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_CARRIER_PERIOD:  carrier_top = value[CARRIER_W-1:0];
        REG_CARRIER_COMPARE: carrier_cmp = value[CARRIER_W-1:0];
        REG_START_MARK:      start_len   = value[TICKS_W-1:0];
        REG_GAP:             gap_len     = value[TICKS_W-1:0];
        REG_ONE_MARK:        one_len     = value[TICKS_W-1:0];
        REG_ZERO_MARK:       zero_len    = value[TICKS_W-1:0];
        REG_TICKS_PER_MS:    ms_len      = value[MS_W-1:0];
        default:             bit_count   = value[BITS_W-1:0];
      endcase
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    // zero length phases last one tick
    function logic [TICKS_W-1:0] at_least_one(logic [TICKS_W-1:0] v);
      return (v == '0) ? TICKS_W'(1) : v;
    endfunction

    function logic [TICKS_W-1:0] phase_len();
      case (phase)
        PH_START: return at_least_one(start_len);
        PH_MARK:  return data_word[bit_idx[4:0]] ? at_least_one(one_len)
                                                 : at_least_one(zero_len);
        default:  return at_least_one(gap_len);
      endcase
    endfunction

    // move on to the next phase of the frame
    function void next_phase();
      logic [BITS_W-1:0] n;
      n = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
      phase_ticks = '0;
      case (phase)
        PH_START: begin
          bit_idx = '0;
          phase = (n > 0) ? PH_GAP : PH_TAIL;
        end
        PH_GAP: phase = PH_MARK;
        PH_MARK: begin
          bit_idx++;
          if (bit_idx >= n) begin
            bit_idx = '0;
            phase = PH_TAIL;
          end else begin
            phase = PH_GAP;
          end
        end
        default: begin
          bit_idx++;
          if (bit_idx >= TAIL_GAPS) begin
            bit_idx = '0;
            if (elapsed_ms < limit_ms) begin
              phase = PH_START;
            end else begin
              phase = PH_IDLE;
              carrier_cnt = '0;
            end
          end
        end
      endcase
    endfunction

    // one accepted input word is one tick of the transmitter
    function void note_tick(logic cmd, logic [WORD_W-1:0] payload,
                            logic [WORD_W-1:0] duration);
      pin_levels_t lv;
      if (phase == PH_IDLE && cmd) begin
        data_word   = payload;
        limit_ms    = duration;
        elapsed_ms  = '0;
        ms_cnt      = '0;
        carrier_cnt = '0;
        phase       = PH_START;
        phase_ticks = '0;
        bit_idx     = '0;
      end
      lv.busy = (phase != PH_IDLE);
      lv.mark = (phase == PH_START) || (phase == PH_MARK);
      lv.pin  = lv.mark ? (carrier_cnt <= carrier_cmp) : 1'b1;
      expected_levels.push_back(lv);

      if (lv.busy) begin
        carrier_cnt = (carrier_cnt >= carrier_top) ? '0 : carrier_cnt + 1'b1;
        ms_cnt = ms_cnt + 1'b1;
        if (ms_cnt >= ((ms_len == '0) ? MS_W'(1) : ms_len)) begin
          ms_cnt = '0;
          if (elapsed_ms != '1) elapsed_ms++;
        end
        phase_ticks++;
        if (phase_ticks >= phase_len()) next_phase();
      end
    endfunction

    function void check_levels(logic pin, logic busy, logic mark);
      pin_levels_t want;
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, pin %b busy %b mark %b",
                 $time, pin, busy, mark);
        return;
      end
      want = expected_levels.pop_front();
      if (want.pin !== pin) begin
        errors++;
        $display("%0t: ir_pin expected %b actual %b", $time, want.pin, pin);
      end
      if (want.busy !== busy) begin
        errors++;
        $display("%0t: busy_res expected %b actual %b", $time, want.busy, busy);
      end
      if (want.mark !== mark) begin
        errors++;
        $display("%0t: in_mark expected %b actual %b", $time, want.mark, mark);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [WORD_W-1:0]    in_payload;
  logic [WORD_W-1:0]    in_duration_ms;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_ir_pin;
  logic                 out_busy_res;
  logic                 out_in_mark;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int unsigned          sender_idle_pct = 0;
  int unsigned          sink_stall_pct = 0;
  ir_frame_scoreboard   words;

  ir_pulse_width_frame_sender_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_payload     (in_payload),
    .in_duration_ms (in_duration_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ir_pin     (out_ir_pin),
    .out_busy_res   (out_busy_res),
    .out_in_mark    (out_in_mark),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // handshakes on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) words.note_tick(in_cmd, in_payload, in_duration_ms);
      if (out_valid && out_ready) words.check_levels(out_ir_pin, out_busy_res, out_in_mark);
    end
  end

  function automatic logic [PDATA_W-1:0] reg_mask(logic [REG_IDX_W-1:0] idx);
    case (idx) inside
      REG_CARRIER_PERIOD, REG_CARRIER_COMPARE: return (1 << CARRIER_W) - 1;
      REG_TICKS_PER_MS:                        return (1 << MS_W) - 1;
      REG_BITS_IN_USE:                         return (1 << BITS_W) - 1;
      default:                                 return (1 << TICKS_W) - 1;
    endcase
  endfunction

  // register write then read back; entered and left at a falling edge
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] got;
    mask    = reg_mask(idx);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = (value & mask) | (~mask & $urandom);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== (value & mask)) begin
      words.errors++;
      $display("%0t: register %0d read expected %h actual %h", $time, idx,
               value & mask, got);
    end
    words.set_reg(idx, value);
  endtask

  task automatic load_settings(input logic [PDATA_W-1:0] period, compare, start_mark,
                               gap, one_mark, zero_mark, per_ms, bits);
    reg_write(REG_CARRIER_PERIOD, period);
    reg_write(REG_CARRIER_COMPARE, compare);
    reg_write(REG_START_MARK, start_mark);
    reg_write(REG_GAP, gap);
    reg_write(REG_ONE_MARK, one_mark);
    reg_write(REG_ZERO_MARK, zero_mark);
    reg_write(REG_TICKS_PER_MS, per_ms);
    reg_write(REG_BITS_IN_USE, bits);
  endtask

  // present one input word; entered and left at a falling edge
  task automatic send_word(input logic cmd, input logic [WORD_W-1:0] payload,
                           input logic [WORD_W-1:0] duration);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_payload     = payload;
    in_duration_ms = duration;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // a repeat time that ends within a few hundred ticks
  function automatic logic [WORD_W-1:0] short_duration();
    logic [MS_W-1:0] per_ms;
    per_ms = (words.ms_len == '0) ? MS_W'(1) : words.ms_len;
    if (per_ms > 150) return '0;
    return $urandom_range(150 / per_ms);
  endfunction

  // starts with random data or plain ticks when idle, ignored starts and plain ticks while busy
  task automatic random_words(input int count);
    repeat (count) begin
      if (words.is_idle()) begin
        if ($urandom_range(2) == 0) send_word(1'b1, $urandom, short_duration());
        else send_word(1'b0, $urandom, $urandom);
      end else begin
        send_word(1'($urandom_range(1)), $urandom, $urandom);
      end
    end
  endtask

  // tick until the transmitter goes idle and every result word is back
  task automatic finish_frames();
    while (!words.is_idle()) send_word(1'b0, $urandom, $urandom);
    in_valid = 1'b0;
    while (words.expected_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // stimulus
  initial begin
    words          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = 1'b0;
    in_payload     = '0;
    in_duration_ms = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // short frames, no idling
    load_settings(7, 3, 3, 2, 3, 1, 5, 4);
    send_word(1'b0, '1, '1);
    send_word(1'b0, '0, '0);
    send_word(1'b1, 32'hFFFF_FFFF, 32'd0);
    send_word(1'b1, 32'h0, 32'hFFFF_FFFF);
    send_word(1'b1, 32'h0, 32'hFFFF_FFFF);
    finish_frames();
    send_word(1'b1, 32'h0, 32'd6);
    finish_frames();
    send_word(1'b1, 32'h5, 32'd1);
    finish_frames();
    random_words(80);
    finish_frames();

    // zero lengths act as one tick, no data bits in a frame
    sender_idle_pct = 88;
    load_settings(1, 0, 0, 0, 0, 0, 0, 0);
    send_word(1'b1, 32'h1234_5678, 32'd3);
    finish_frames();
    random_words(80);
    finish_frames();

    // widest carrier, slowest millisecond, bit count saturating
    sender_idle_pct = 0;
    sink_stall_pct  = 88;
    load_settings(32'hFFFF, 32'hFFFF, 2, 1, 2, 1, 32'hF_FFFF, 63);
    send_word(1'b1, 32'hFFFF_FFFF, 32'd0);
    finish_frames();
    random_words(80);
    finish_frames();

    // longest phase lengths, idle ticks only
    sink_stall_pct = 0;
    load_settings(1, 0, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 1, 32);
    repeat (8) send_word(1'b0, $urandom, $urandom);
    finish_frames();

    // full data word, both sides idling
    sender_idle_pct = 31;
    sink_stall_pct  = 31;
    load_settings(4, 2, 5, 3, 4, 2, 3, 32);
    random_words(80);
    finish_frames();

    // single bit frames repeated many times
    sender_idle_pct = 88;
    sink_stall_pct  = 0;
    load_settings(2, 1, 1, 1, 2, 1, 1, 1);
    random_words(80);
    finish_frames();

    if (words.errors == 0 && words.expected_levels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- ir_pulse_width_frame_sender_unit.f -----
rtl/irpw_pkg.sv
rtl/ir_pulse_width_frame_sender_unit.sv
rtl/irpw_checker.sv
tb/tb.sv
